@@ rtl/core/cc24_pkg.sv @@
// types and constants for the 24x crank and cam position decoder
package cc24_pkg;

	localparam logic [2:0] OP_CRANK_FALL = 3'd0;
	localparam logic [2:0] OP_CRANK_RISE = 3'd1;
	localparam logic [2:0] OP_CAM_FALL   = 3'd2;
	localparam logic [2:0] OP_CAM_RISE   = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	localparam logic [5:0]  TEETH_PER_REV    = 6'd24;
	localparam logic [5:0]  TOOTH_LAST_CRANK = 6'd23;
	localparam logic [5:0]  TOOTH_LAST_CAM   = 6'd47;
	localparam logic [5:0]  TOOTH_CAM_RISE   = 6'd24;
	localparam logic [5:0]  TOOTH_CAM_FALL   = 6'd0;
	localparam logic [2:0]  PULSES_TO_SYNC   = 3'd5;
	localparam logic [2:0]  PULSE_RUN_MAX    = 3'd7;
	localparam logic [15:0] UNITS_PER_TOOTH  = 16'd960;
	localparam logic [9:0]  FRAC_MAX         = 10'd959;
	localparam logic [15:0] RPM_MAX          = 16'd65535;
	localparam logic [31:0] TPS_RESET        = 32'd1000000;

	localparam int unsigned REM_W     = 48;
	localparam logic [3:0]  FRAC_LAST = 4'd9;
	localparam logic [3:0]  RPM_LAST  = 4'd15;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] event_time;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  tooth_index;
		logic        is_synced;
		logic        has_cam;
		logic [31:0] period_ticks;
		logic [14:0] crank_angle;
		logic [15:0] cam_angle;
		logic [15:0] engine_rpm;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} seq_state_t;

endpackage

@@ rtl/core/cc24_ifs.sv @@
// valid/ready channels for event and result words
interface cc24_in_if;
	import cc24_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cc24_out_if;
	import cc24_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/crank_cam_24x_decoder.sv @@
// 24x crank and cam position decoder with serial divider for angle fraction and rpm
// Each event word (crank fall, crank rise, cam fall, cam rise, query) updates the
// tooth tracker in its accept cycle and then produces one result word. The in-tooth
// fraction and the rpm come from one shared 48-bit compare-subtract unit doing
// restoring division by the crank period: 10 steps for the fraction and 16 for rpm.
// Results load into the output register after ST_PREP and, for a nonzero period,
// ST_DIV; the next event is taken the cycle after. The output register lets a new
// event be processed while the previous result waits. The user writes
// ticks_per_second (cfg_we/cfg_wdata) only while no event is in flight, unchecked.
module crank_cam_24x_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	cc24_in_if.sink      req,
	cc24_out_if.source   rsp
);
	import cc24_pkg::*;

	seq_state_t state_q, state_d;

	logic [5:0]  tooth_q, tooth_n;
	logic [2:0]  pulse_q, pulse_n;
	logic        cam_seen_q, cam_seen_n;
	logic        cam_present_q, cam_present_n;
	logic        sync_q, sync_n;
	logic [31:0] last_crank_q, last_crank_n;
	logic [31:0] last_cam_q, last_cam_n;
	logic [31:0] period_q, period_n;
	logic [31:0] tps_q;
	logic [31:0] t_q;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] div_q;
	logic [15:0]      quo_q;
	logic [3:0]       cnt_q;
	logic             phase_q;
	logic             sat_q;
	logic [9:0]       frac_q;
	logic [15:0]      rpm_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic        accept;
	logic [31:0] ev_t;
	logic [31:0] dt_crank;
	logic [31:0] dt_cam;
	logic [5:0]  tooth_inc;
	logic [5:0]  limit;
	logic        advance;
	logic [34:0] rise_five;
	logic [34:0] rise_three;
	logic [2:0]  pulse_inc;

	logic [31:0]      dt_post;
	logic [REM_W-1:0] frac_num;
	logic [33:0]      rpm_num;
	logic             ge;
	logic [REM_W-1:0] rem_sub;
	logic [15:0]      quo_next;
	logic             out_load;
	logic [4:0]       tooth_mod;
	out_word_t        res;

	assign accept   = req.valid && req.ready;
	assign ev_t     = req.data.event_time;
	assign dt_crank = ev_t - last_crank_q;
	assign dt_cam   = ev_t - last_cam_q;

	// tooth tracker update for the incoming event
	always_comb begin
		tooth_n       = tooth_q;
		pulse_n       = pulse_q;
		cam_seen_n    = cam_seen_q;
		cam_present_n = cam_present_q;
		sync_n        = sync_q;
		last_crank_n  = last_crank_q;
		last_cam_n    = last_cam_q;
		period_n      = period_q;
		tooth_inc     = tooth_q + 6'd1;
		limit         = (!cam_present_q && !cam_seen_q) ? TOOTH_LAST_CRANK : TOOTH_LAST_CAM;
		advance       = (tooth_q != TOOTH_CAM_FALL && tooth_q != TEETH_PER_REV) ||
		                (dt_cam > {2'b00, dt_crank[31:2]});
		rise_five     = {1'b0, dt_crank, 2'b00} + {3'b000, dt_crank};
		rise_three    = {2'b00, period_q, 1'b0} + {3'b000, period_q};
		pulse_inc     = pulse_q + 3'd1;
		case (req.data.opcode)
			OP_CRANK_FALL: begin
				period_n     = dt_crank;
				last_crank_n = ev_t;
				if (advance) begin
					if (tooth_inc > limit) begin
						tooth_n       = 6'd0;
						cam_present_n = cam_seen_q;
						cam_seen_n    = 1'b0;
					end else begin
						tooth_n = tooth_inc;
					end
				end
			end
			OP_CRANK_RISE: begin
				if (!cam_present_q) begin
					if (rise_five > rise_three) begin
						pulse_n = 3'd0;
					end else if (pulse_q < PULSE_RUN_MAX) begin
						pulse_n = pulse_inc;
						if (pulse_inc == PULSES_TO_SYNC) begin
							tooth_n = {3'b000, PULSES_TO_SYNC};
							sync_n  = 1'b1;
						end
					end
				end
			end
			OP_CAM_FALL, OP_CAM_RISE: begin
				last_cam_n    = ev_t;
				cam_seen_n    = 1'b1;
				cam_present_n = 1'b1;
				sync_n        = 1'b1;
				tooth_n       = (req.data.opcode == OP_CAM_RISE) ? TOOTH_CAM_RISE
				                                                  : TOOTH_CAM_FALL;
			end
			OP_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	// divider operands and the shared compare-subtract step
	assign dt_post  = t_q - last_crank_q;
	assign frac_num = {6'd0, dt_post, 10'd0} - {10'd0, dt_post, 6'd0};
	assign rpm_num  = 34'(({1'b0, tps_q, 2'b00} + {3'b000, tps_q}) >> 1);
	assign ge       = rem_q >= div_q;
	assign rem_sub  = rem_q - div_q;
	assign quo_next = {quo_q[14:0], ge};

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = (period_q == 32'd0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == 4'd0 && phase_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tooth_q       <= 6'd0;
			pulse_q       <= 3'd0;
			cam_seen_q    <= 1'b0;
			cam_present_q <= 1'b1;
			sync_q        <= 1'b0;
			last_crank_q  <= 32'd0;
			last_cam_q    <= 32'd0;
			period_q      <= 32'd0;
			tps_q         <= TPS_RESET;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			if (accept) begin
				tooth_q       <= tooth_n;
				pulse_q       <= pulse_n;
				cam_seen_q    <= cam_seen_n;
				cam_present_q <= cam_present_n;
				sync_q        <= sync_n;
				last_crank_q  <= last_crank_n;
				last_cam_q    <= last_cam_n;
				period_q      <= period_n;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= ev_t;
		end
		case (state_q)
			ST_PREP: begin
				rem_q   <= frac_num;
				div_q   <= {7'd0, period_q, 9'd0};
				cnt_q   <= FRAC_LAST;
				phase_q <= 1'b0;
				sat_q   <= dt_post >= period_q;
				quo_q   <= 16'd0;
				frac_q  <= 10'd0;
				rpm_q   <= 16'd0;
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sub : rem_q;
				div_q <= div_q >> 1;
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					if (!phase_q) begin
						frac_q  <= sat_q ? FRAC_MAX : quo_next[9:0];
						rem_q   <= {14'd0, rpm_num};
						div_q   <= {1'b0, period_q, 15'd0};
						cnt_q   <= RPM_LAST;
						phase_q <= 1'b1;
						sat_q   <= {14'd0, rpm_num[33:16]} >= period_q;
						quo_q   <= 16'd0;
					end else begin
						rpm_q <= sat_q ? RPM_MAX : quo_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result assembly
	always_comb begin
		tooth_mod        = (tooth_q >= TEETH_PER_REV) ? 5'(tooth_q - TEETH_PER_REV)
		                                              : tooth_q[4:0];
		res.tooth_index  = tooth_q;
		res.is_synced    = sync_q;
		res.has_cam      = cam_present_q;
		res.period_ticks = period_q;
		res.crank_angle  = 15'(16'(16'({11'd0, tooth_mod} * UNITS_PER_TOOTH)
		                   + {6'd0, frac_q}));
		res.cam_angle    = 16'(16'({10'd0, tooth_q} * UNITS_PER_TOOTH) + {6'd0, frac_q});
		res.engine_rpm   = rpm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

@@ tb/crank_cam_24x_decoder_tb.sv @@
// self-checking testbench for the 24x crank and cam position decoder
module crank_cam_24x_decoder_tb;
	import cc24_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 190;
	localparam int PRINT_CAP     = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	cc24_in_if  req_ch ();
	cc24_out_if rsp_ch ();

	crank_cam_24x_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// decoder state as predicted
	logic [5:0]  tooth_m;
	logic [2:0]  pulses_m;
	logic        cam_seen_m;
	logic        cam_live_m;
	logic        synced_m;
	logic [31:0] crank_t_m;
	logic [31:0] cam_t_m;
	logic [31:0] period_m;
	logic [31:0] tick_rate_m;

	in_word_t  event_queue[$];
	out_word_t results_due[$];
	out_word_t due_word;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int results_checked;
	int mismatches;
	int quiet_cycles;

	logic [31:0] gen_t;
	int          gen_tooth;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic out_word_t decode_event(logic [2:0] op, logic [31:0] t);
		out_word_t   w;
		logic [31:0] dt;
		logic [31:0] since_cam;
		logic [63:0] frac;
		logic [63:0] rpm;
		logic [63:0] angle;
		logic [5:0]  wrap_at;
		case (op)
			OP_CRANK_FALL: begin
				period_m = t - crank_t_m;
				since_cam = t - cam_t_m;
				if ((tooth_m != TOOTH_CAM_FALL && tooth_m != TOOTH_CAM_RISE) ||
				    since_cam > (period_m >> 2)) begin
					tooth_m = tooth_m + 6'd1;
					wrap_at = (!cam_live_m && !cam_seen_m) ? TOOTH_LAST_CRANK : TOOTH_LAST_CAM;
					if (tooth_m > wrap_at) begin
						tooth_m = 6'd0;
						cam_live_m = cam_seen_m;
						cam_seen_m = 1'b0;
					end
				end
				crank_t_m = t;
			end
			OP_CRANK_RISE: begin
				if (!cam_live_m) begin
					dt = t - crank_t_m;
					if (64'(dt) * 64'd5 > 64'(period_m) * 64'd3) begin
						pulses_m = 3'd0;
					end else if (pulses_m < PULSE_RUN_MAX) begin
						pulses_m = pulses_m + 3'd1;
						if (pulses_m == PULSES_TO_SYNC) begin
							tooth_m = 6'(PULSES_TO_SYNC);
							synced_m = 1'b1;
						end
					end
				end
			end
			OP_CAM_FALL, OP_CAM_RISE: begin
				cam_t_m = t;
				cam_seen_m = 1'b1;
				cam_live_m = 1'b1;
				synced_m = 1'b1;
				tooth_m = (op == OP_CAM_RISE) ? TOOTH_CAM_RISE : TOOTH_CAM_FALL;
			end
			default: begin
			end
		endcase
		dt = t - crank_t_m;
		frac = 64'd0;
		rpm = 64'd0;
		if (period_m != 32'd0) begin
			frac = (64'(dt) * 64'(UNITS_PER_TOOTH)) / 64'(period_m);
			if (frac > 64'(FRAC_MAX))
				frac = 64'(FRAC_MAX);
			rpm = (64'(tick_rate_m) * 64'd60 / 64'd24) / 64'(period_m);
			if (rpm > 64'(RPM_MAX))
				rpm = 64'(RPM_MAX);
		end
		w.tooth_index = tooth_m;
		w.is_synced = synced_m;
		w.has_cam = cam_live_m;
		w.period_ticks = period_m;
		angle = 64'(tooth_m % TEETH_PER_REV) * 64'(UNITS_PER_TOOTH) + frac;
		w.crank_angle = angle[14:0];
		angle = 64'(tooth_m) * 64'(UNITS_PER_TOOTH) + frac;
		w.cam_angle = angle[15:0];
		w.engine_rpm = rpm[15:0];
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_checked, name, got, want));
	endtask

	task automatic put_event(logic [2:0] op, logic [31:0] t);
		in_word_t w;
		w.opcode = op;
		w.event_time = t;
		event_queue.push_back(w);
		items_sent++;
	endtask

	task automatic wait_idle();
		while (event_queue.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tick_rate(logic [31:0] rate);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		tick_rate_m = rate;
	endtask

	// one stretch of running engine, with or without cam edges
	task automatic run_engine(bit with_cam, int teeth, int unsigned base_per);
		int          k;
		int unsigned per;
		int unsigned rise_dt;
		int unsigned off;
		int          pick;
		for (k = 0; k < teeth; k++) begin
			per = base_per - base_per / 20 + $urandom_range(base_per / 10);
			if (with_cam && (gen_tooth == 0 || gen_tooth == 24) && $urandom_range(19) != 0) begin
				off = $urandom_range(per / 4 + 2);
				put_event((gen_tooth == 0) ? OP_CAM_FALL : OP_CAM_RISE, gen_t + per - off);
			end
			gen_t = gen_t + per;
			put_event(OP_CRANK_FALL, gen_t);
			pick = $urandom_range(9);
			if (pick < 6)
				rise_dt = $urandom_range((3 * per) / 5);
			else if (pick == 6)
				rise_dt = (3 * per) / 5;
			else if (pick == 7)
				rise_dt = (3 * per) / 5 + 1;
			else
				rise_dt = $urandom_range(per, (3 * per) / 5 + 1);
			put_event(OP_CRANK_RISE, gen_t + rise_dt);
			if ($urandom_range(5) == 0)
				put_event(OP_QUERY, gen_t + $urandom_range(2 * per));
			gen_tooth = (gen_tooth + 1) % 48;
		end
	endtask

	task automatic put_noise(int n);
		int          k;
		logic [31:0] t;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(2))
				0: t = $urandom;
				1: t = gen_t;
				default: t = gen_t + $urandom_range(1000);
			endcase
			put_event(3'($urandom_range(int'(OP_QUERY))), t);
		end
	endtask

	function automatic int unsigned pick_period();
		case ($urandom_range(9))
			0: return $urandom_range(1, 40);
			1: return $urandom_range(100000, 2000000);
			default: return $urandom_range(50, 50000);
		endcase
	endfunction

	// driver: presents queued words, idles at random between them
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				results_due.push_back(decode_event(req_ch.data.opcode, req_ch.data.event_time));
				void'(event_queue.pop_front());
			end
			if (req_ch.valid && !req_ch.ready) begin
				req_ch.valid <= 1'b1;
			end else if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= event_queue[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result word against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing due",
						results_checked));
				end else begin
					due_word = results_due.pop_front();
					compare_field("tooth_index", rsp_ch.data.tooth_index, due_word.tooth_index);
					compare_field("is_synced", rsp_ch.data.is_synced, due_word.is_synced);
					compare_field("has_cam", rsp_ch.data.has_cam, due_word.has_cam);
					compare_field("period_ticks", rsp_ch.data.period_ticks, due_word.period_ticks);
					compare_field("crank_angle", rsp_ch.data.crank_angle, due_word.crank_angle);
					compare_field("cam_angle", rsp_ch.data.cam_angle, due_word.cam_angle);
					compare_field("engine_rpm", rsp_ch.data.engine_rpm, due_word.engine_rpm);
				end
				results_checked++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int          phase;
		int          phase_end;
		logic [31:0] rate;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 32'd0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 45;
		items_sent = 0;
		results_checked = 0;
		mismatches = 0;
		quiet_cycles = 0;
		tooth_m = 6'd0;
		pulses_m = 3'd0;
		cam_seen_m = 1'b0;
		cam_live_m = 1'b1;
		synced_m = 1'b0;
		crank_t_m = 32'd0;
		cam_t_m = 32'd0;
		period_m = 32'd0;
		tick_rate_m = TPS_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_event(OP_QUERY, 32'h1234_5678);      // zero period after reset
		put_event(OP_CRANK_FALL, 32'd100);
		put_event(OP_CRANK_FALL, 32'd200);
		put_event(OP_QUERY, 32'd5000);           // fraction clamp
		put_event(OP_CRANK_RISE, 32'd230);       // ignored with cam present
		put_event(OP_CAM_FALL, 32'd290);
		put_event(OP_CRANK_FALL, 32'd300);       // close to cam edge
		put_event(OP_CRANK_FALL, 32'd400);
		put_event(OP_CAM_RISE, 32'd475);
		put_event(OP_CRANK_FALL, 32'd500);       // exactly a quarter period
		put_event(OP_CAM_FALL, 32'd574);
		put_event(OP_CRANK_FALL, 32'd600);       // just past a quarter period
		put_event(OP_CRANK_FALL, 32'd601);       // rpm saturates
		put_event(OP_CRANK_FALL, 32'd601);       // zero period
		put_event(OP_QUERY, 32'hFFFF_FFFF);
		put_event(OP_CRANK_FALL, 32'hFFFF_FFF0);
		put_event(OP_CRANK_FALL, 32'h0000_0010); // timer wrap
		put_event(OP_CRANK_RISE, 32'h0000_0020);
		put_event(OP_QUERY, 32'h8000_0000);
		wait_idle();

		gen_t = $urandom;
		gen_tooth = 0;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: rate = TPS_RESET;
				1: rate = 32'hFFFF_FFFF;
				2: rate = 32'd1;
				3: rate = $urandom;
				4: rate = $urandom_range(1000, 50000000);
				default: rate = 32'hFFFF_FFFF;
			endcase
			set_tick_rate(rate);
			send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 45 : 0;
			recv_idle_pct = (phase < 2) ? 45 : (phase < 4) ? 16 : 0;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: run_engine(1'b1, $urandom_range(10, 60), pick_period());
					5, 6, 7: run_engine(1'b0, $urandom_range(50, 130), pick_period());
					default: put_noise($urandom_range(1, 8));
				endcase
			end
			// hold the sender until every result is back
			wait_idle();
		end

		$display("run covered %0d events and %0d result words over six tick rate settings",
			items_sent, results_checked);
		$display("cam sync, crank-only pulse sync, timer wrap and three idle patterns exercised");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
